### hdl/qrs_pkg.sv
// Shared types, constants and saturation helper for the quadratic root solver.
package qrs_pkg;

  // Field widths that follow from the fixed 32-bit coefficient format
  localparam int unsigned WORD_W = 32;
  localparam int unsigned RAD_W  = 66;  // discriminant magnitude, padded to even
  localparam int unsigned ROOT_W = 33;  // floor(sqrt) of a 65-bit value
  localparam int unsigned NUM_W  = 35;  // |-b +/- sqrt D| and friends
  localparam int unsigned DEN_W  = 33;  // |2a| or |b|

  // Case codes
  localparam logic [2:0] CODE_INF  = 3'd0;
  localparam logic [2:0] CODE_NONE = 3'd1;
  localparam logic [2:0] CODE_LIN  = 3'd2;
  localparam logic [2:0] CODE_TWO  = 3'd3;
  localparam logic [2:0] CODE_DBL  = 3'd4;
  localparam logic [2:0] CODE_CPX  = 3'd5;

  typedef struct packed {
    logic signed [WORD_W-1:0] coef_quad;
    logic signed [WORD_W-1:0] coef_lin;
    logic signed [WORD_W-1:0] coef_const;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               case_code;
    logic signed [WORD_W-1:0] root_one;
    logic signed [WORD_W-1:0] root_two;
    logic signed [WORD_W-1:0] discriminant;
    logic                     overflow;
  } out_item_t;

  // Saturated word plus overflow mark
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              ovf;
  } sat_t;

  // Item state carried alongside the square root
  typedef struct packed {
    logic [2:0]        code;
    logic              an;
    logic [32:0]       nb;      // -b, two's complement
    logic [WORD_W-1:0] bm;
    logic [WORD_W-1:0] cm;
    logic [DEN_W-1:0]  den;
    logic              lin_neg;
    logic [WORD_W-1:0] dq;
    logic              dovf;
  } mid_t;

  // Item state carried alongside the dividers
  typedef struct packed {
    logic [2:0]        code;
    logic [WORD_W-1:0] dq;
    logic              dovf;
  } fin_t;

  // Sign and magnitude to a saturated 32-bit two's complement word
  function automatic sat_t sat_word(input logic neg, input logic [RAD_W-1:0] mag);
    sat_t r;
    logic ne;
    ne = neg && (mag != '0);
    if (!ne) begin
      r.ovf  = mag > RAD_W'(32'h7FFF_FFFF);
      r.word = r.ovf ? 32'h7FFF_FFFF : mag[WORD_W-1:0];
    end else begin
      r.ovf  = mag > RAD_W'(33'h0_8000_0000);
      r.word = r.ovf ? 32'h8000_0000 : (~mag[WORD_W-1:0] + 32'd1);
    end
    return r;
  endfunction

endpackage

### hdl/quadratic_root_solver.sv
// Top level of the pipelined quadratic root solver.
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+----------------------------
//   in       | in  | in_valid_i / in_stall_o | in_data_i  (coefficients)
//   out      | out | out_valid_o/ out_stall_i| out_data_o (code, roots, D)
//   cfg      | in  | cfg_we_i                | cfg_data_i (zero tolerance)
//
// One item per cycle unless a held result stalls the output; the pipeline has
// three front stages (magnitudes, products, discriminant), 33 square root
// stages, one numerator stage, 33 divider stages and the output register.
// Reset clears all valid bits and the tolerance register.
// A stalled output with a valid result freezes the whole pipeline; in_stall_o follows it.
module quadratic_root_solver #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qrs_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qrs_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int unsigned RW = qrs_pkg::RAD_W;
  localparam int unsigned NW = qrs_pkg::NUM_W;

  logic en;
  logic [15:0] tol_q;

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // ---------------- stage A: magnitudes and zero tests ----------------
  logic [31:0] a_u, b_u, c_u, am_d, bm_d, cm_d, tol_ext;
  logic        sa_vld_q, sa_an_q, sa_bn_q, sa_cn_q, sa_az_q, sa_bz_q, sa_cz_q;
  logic [31:0] sa_am_q, sa_bm_q, sa_cm_q;

  assign a_u     = in_data_i.coef_quad;
  assign b_u     = in_data_i.coef_lin;
  assign c_u     = in_data_i.coef_const;
  assign am_d    = a_u[31] ? (~a_u + 32'd1) : a_u;
  assign bm_d    = b_u[31] ? (~b_u + 32'd1) : b_u;
  assign cm_d    = c_u[31] ? (~c_u + 32'd1) : c_u;
  assign tol_ext = {16'b0, tol_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
    end else if (en) begin
      sa_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_am_q <= am_d;
      sa_bm_q <= bm_d;
      sa_cm_q <= cm_d;
      sa_an_q <= a_u[31];
      sa_bn_q <= b_u[31];
      sa_cn_q <= c_u[31];
      sa_az_q <= (am_d == '0) || (am_d < tol_ext);
      sa_bz_q <= (bm_d == '0) || (bm_d < tol_ext);
      sa_cz_q <= (cm_d == '0) || (cm_d < tol_ext);
    end
  end

  // ---------------- stage B: b*b and a*c ----------------
  logic        sb_vld_q, sb_an_q, sb_bn_q, sb_cn_q, sb_az_q, sb_bz_q, sb_cz_q;
  logic [31:0] sb_am_q, sb_bm_q, sb_cm_q;
  logic [63:0] sb_p_q, sb_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_vld_q <= 1'b0;
    end else if (en) begin
      sb_vld_q <= sa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_p_q  <= {32'b0, sa_bm_q} * {32'b0, sa_bm_q};
      sb_m_q  <= {32'b0, sa_am_q} * {32'b0, sa_cm_q};
      sb_am_q <= sa_am_q;
      sb_bm_q <= sa_bm_q;
      sb_cm_q <= sa_cm_q;
      sb_an_q <= sa_an_q;
      sb_bn_q <= sa_bn_q;
      sb_cn_q <= sa_cn_q;
      sb_az_q <= sa_az_q;
      sb_bz_q <= sa_bz_q;
      sb_cz_q <= sa_cz_q;
    end
  end

  // ---------------- stage C: discriminant and classification ----------------
  logic [RW-1:0] p_x, m4_x, dmag, dsh, tol_sh;
  logic          dneg;
  qrs_pkg::sat_t dsat;
  qrs_pkg::mid_t mid_d, sc_mid_q;
  logic [RW-1:0] sc_rad_q;
  logic          sc_vld_q;

  assign p_x    = RW'(sb_p_q);
  assign m4_x   = RW'(sb_m_q) << 2;
  assign tol_sh = RW'(tol_q) << FRAC_BITS;

  // |b*b - 4ac| and its sign
  always_comb begin
    if ((sb_an_q != sb_cn_q) && (sb_m_q != '0)) begin
      dmag = p_x + m4_x;
      dneg = 1'b0;
    end else if (p_x >= m4_x) begin
      dmag = p_x - m4_x;
      dneg = 1'b0;
    end else begin
      dmag = m4_x - p_x;
      dneg = 1'b1;
    end
  end

  assign dsh  = dmag >> FRAC_BITS;
  assign dsat = qrs_pkg::sat_word(dneg, dsh);

  always_comb begin
    mid_d.an      = sb_an_q;
    mid_d.nb      = sb_bn_q ? {1'b0, sb_bm_q} : (~{1'b0, sb_bm_q} + 33'd1);
    mid_d.bm      = sb_bm_q;
    mid_d.cm      = sb_cm_q;
    mid_d.lin_neg = (sb_cn_q == sb_bn_q);
    if (sb_az_q) begin
      mid_d.den  = {1'b0, sb_bm_q};
      mid_d.dq   = '0;
      mid_d.dovf = 1'b0;
      if (sb_bz_q) begin
        mid_d.code = sb_cz_q ? qrs_pkg::CODE_INF : qrs_pkg::CODE_NONE;
      end else begin
        mid_d.code = qrs_pkg::CODE_LIN;
      end
    end else begin
      mid_d.den  = {sb_am_q, 1'b0};
      mid_d.dq   = dsat.word;
      mid_d.dovf = dsat.ovf;
      if ((dmag == '0) || (dmag < tol_sh)) begin
        mid_d.code = qrs_pkg::CODE_DBL;
      end else begin
        mid_d.code = dneg ? qrs_pkg::CODE_CPX : qrs_pkg::CODE_TWO;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q <= 1'b0;
    end else if (en) begin
      sc_vld_q <= sb_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_mid_q <= mid_d;
      sc_rad_q <= dmag;
    end
  end

  // ---------------- square root ----------------
  logic                         sq_vld;
  logic [qrs_pkg::ROOT_W-1:0]   sq_root;
  qrs_pkg::mid_t                sq_mid;

  qrs_sqrt #(
    .TAG_W ($bits(qrs_pkg::mid_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sc_vld_q),
    .rad_i  (sc_rad_q),
    .tag_i  (sc_mid_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .tag_o  (sq_mid)
  );

  // ---------------- stage D: numerators and signs ----------------
  logic [NW-1:0] nbx, sx, sum1, sum2, mag1, mag2;
  logic [NW-1:0] n1_d, n2_d;
  logic          neg1_d, neg2_d, use2_d, bneg;
  qrs_pkg::fin_t fin_d;

  logic                        sd_vld_q, sd_neg1_q, sd_neg2_q, sd_use2_q;
  logic [NW-1:0]               sd_n1_q, sd_n2_q;
  logic [qrs_pkg::DEN_W-1:0]   sd_den_q;
  qrs_pkg::fin_t               sd_fin_q;

  assign nbx  = {{2{sq_mid.nb[32]}}, sq_mid.nb};
  assign sx   = NW'(sq_root);
  assign sum1 = nbx + sx;
  assign sum2 = nbx - sx;
  assign mag1 = sum1[NW-1] ? (~sum1 + NW'(1)) : sum1;
  assign mag2 = sum2[NW-1] ? (~sum2 + NW'(1)) : sum2;
  assign bneg = sq_mid.nb[32];

  always_comb begin
    n1_d   = NW'(sq_mid.bm);
    neg1_d = bneg != sq_mid.an;
    n2_d   = '0;
    neg2_d = 1'b0;
    use2_d = 1'b0;
    unique case (sq_mid.code)
      qrs_pkg::CODE_LIN: begin
        n1_d   = NW'(sq_mid.cm);
        neg1_d = sq_mid.lin_neg;
      end
      qrs_pkg::CODE_TWO: begin
        n1_d   = mag1;
        neg1_d = sum1[NW-1] != sq_mid.an;
        n2_d   = mag2;
        neg2_d = sum2[NW-1] != sq_mid.an;
        use2_d = 1'b1;
      end
      qrs_pkg::CODE_CPX: begin
        n2_d   = sx;
        neg2_d = sq_mid.an;
        use2_d = 1'b1;
      end
      default: begin
        // double root uses -b/2a; no-root cases are masked at the output
      end
    endcase
    fin_d.code = sq_mid.code;
    fin_d.dq   = sq_mid.dq;
    fin_d.dovf = sq_mid.dovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_vld_q <= 1'b0;
    end else if (en) begin
      sd_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_n1_q   <= n1_d;
      sd_n2_q   <= n2_d;
      sd_neg1_q <= neg1_d;
      sd_neg2_q <= neg2_d;
      sd_use2_q <= use2_d;
      sd_den_q  <= sq_mid.den;
      sd_fin_q  <= fin_d;
    end
  end

  // ---------------- dividers ----------------
  logic           d1_vld, d2_vld, d2_use2;
  qrs_pkg::sat_t  d1_res, d2_res;
  qrs_pkg::fin_t  d1_fin;

  qrs_div #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     ($bits(qrs_pkg::fin_t))
  ) u_div_one (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sd_vld_q),
    .num_i  (sd_n1_q),
    .den_i  (sd_den_q),
    .neg_i  (sd_neg1_q),
    .tag_i  (sd_fin_q),
    .vld_o  (d1_vld),
    .res_o  (d1_res),
    .tag_o  (d1_fin)
  );

  qrs_div #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (1)
  ) u_div_two (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sd_vld_q),
    .num_i  (sd_n2_q),
    .den_i  (sd_den_q),
    .neg_i  (sd_neg2_q),
    .tag_i  (sd_use2_q),
    .vld_o  (d2_vld),
    .res_o  (d2_res),
    .tag_o  (d2_use2)
  );

  // ---------------- output register ----------------
  qrs_pkg::out_item_t out_d, out_q;
  logic               out_vld_q;

  always_comb begin
    out_d.case_code    = d1_fin.code;
    out_d.discriminant = d1_fin.dq;
    if ((d1_fin.code == qrs_pkg::CODE_INF) || (d1_fin.code == qrs_pkg::CODE_NONE)) begin
      out_d.root_one = '0;
      out_d.root_two = '0;
      out_d.overflow = 1'b0;
    end else begin
      out_d.root_one = d1_res.word;
      out_d.root_two = d2_use2 ? d2_res.word : d1_res.word;
      out_d.overflow = d1_fin.dovf | d1_res.ovf | (d2_use2 & d2_res.ovf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d1_vld & d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // whole pipe moves unless a finished result is held
  assign en          = !(out_vld_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.case_code == qrs_pkg::CODE_INF) ||
                    (out_data_o.case_code == qrs_pkg::CODE_NONE))
    |-> (out_data_o.root_one == '0) && (out_data_o.root_two == '0) &&
        (out_data_o.discriminant == '0) && !out_data_o.overflow)
    else $error("degenerate case carries nonzero words");

  a_single_root_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.case_code == qrs_pkg::CODE_LIN) ||
                    (out_data_o.case_code == qrs_pkg::CODE_DBL))
    |-> out_data_o.root_one == out_data_o.root_two)
    else $error("single root case with differing root words");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.case_code <= qrs_pkg::CODE_CPX)
    else $error("case code out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");
`endif

endmodule

### hdl/qrs_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
module qrs_sqrt #(
  parameter int unsigned TAG_W = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [qrs_pkg::RAD_W-1:0]     rad_i,
  input  logic [TAG_W-1:0]              tag_i,
  output logic                          vld_o,
  output logic [qrs_pkg::ROOT_W-1:0]    root_o,
  output logic [TAG_W-1:0]              tag_o
);

  localparam int unsigned NS    = qrs_pkg::ROOT_W;
  localparam int unsigned RW    = qrs_pkg::RAD_W;
  localparam int unsigned REM_W = qrs_pkg::ROOT_W + 3;

  logic [REM_W-1:0] rem_q  [NS];
  logic [NS-1:0]    root_q [NS];
  logic [RW-1:0]    rad_q  [NS];
  logic [TAG_W-1:0] tag_q  [NS];
  logic [NS-1:0]    vld_q;

  logic [REM_W-1:0] rem_p  [NS];
  logic [NS-1:0]    root_p [NS];
  logic [RW-1:0]    rad_p  [NS];
  logic [TAG_W-1:0] tag_p  [NS];
  logic [NS-1:0]    vld_p;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [REM_W-1:0] rem_t;
    logic [REM_W-1:0] trial;
    logic             ge;

    // previous stage or the input
    if (k == 0) begin : g_first
      assign rem_p[k]  = '0;
      assign root_p[k] = '0;
      assign rad_p[k]  = rad_i;
      assign tag_p[k]  = tag_i;
      assign vld_p[k]  = vld_i;
    end else begin : g_next
      assign rem_p[k]  = rem_q[k-1];
      assign root_p[k] = root_q[k-1];
      assign rad_p[k]  = rad_q[k-1];
      assign tag_p[k]  = tag_q[k-1];
      assign vld_p[k]  = vld_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_t = {rem_p[k][REM_W-3:0], rad_p[k][RW-1 -: 2]};
    assign trial = {1'b0, root_p[k], 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_t - trial) : rem_t;
        root_q[k] <= {root_p[k][NS-2:0], ge};
        rad_q[k]  <= {rad_p[k][RW-3:0], 2'b00};
        tag_q[k]  <= tag_p[k];
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign root_o = root_q[NS-1];
  assign tag_o  = tag_q[NS-1];

endmodule

### hdl/qrs_div.sv
// Pipelined restoring divider giving a saturated Q-format quotient, one bit per stage.
module qrs_div #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned TAG_W     = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [qrs_pkg::NUM_W-1:0]    num_i,
  input  logic [qrs_pkg::DEN_W-1:0]    den_i,
  input  logic                         neg_i,
  input  logic [TAG_W-1:0]             tag_i,
  output logic                         vld_o,
  output qrs_pkg::sat_t                res_o,
  output logic [TAG_W-1:0]             tag_o
);

  localparam int unsigned QW = qrs_pkg::WORD_W;
  localparam int unsigned NS = QW + 1;  // overflow check, then one stage per bit
  localparam int unsigned RW = qrs_pkg::NUM_W + FRAC_BITS;
  localparam int unsigned DW = qrs_pkg::DEN_W;
  localparam int unsigned CW = ((RW > DW + QW) ? RW : (DW + QW)) + 1;

  logic [RW-1:0]    rem_q [NS];
  logic [DW-1:0]    den_q [NS];
  logic [QW-1:0]    quo_q [NS];
  logic [TAG_W-1:0] tag_q [NS];
  logic [NS-1:0]    big_q;
  logic [NS-1:0]    neg_q;
  logic [NS-1:0]    vld_q;

  // first stage: quotient would need more than 32 bits
  logic [RW-1:0] num_sh;
  logic          big_d;

  assign num_sh = {num_i, FRAC_BITS'(0)};
  assign big_d  = CW'(num_sh) >= (CW'(den_i) << QW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_sh;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      big_q[0] <= big_d;
      neg_q[0] <= neg_i;
      tag_q[0] <= tag_i;
    end
  end

  // bit stages, most significant quotient bit first
  for (genvar i = 1; i < NS; i++) begin : g_bit
    logic [CW-1:0] dsh;
    logic          ge;

    assign dsh = CW'(den_q[i-1]) << (QW - i);
    assign ge  = CW'(rem_q[i-1]) >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? (rem_q[i-1] - dsh[RW-1:0]) : rem_q[i-1];
        den_q[i] <= den_q[i-1];
        quo_q[i] <= {quo_q[i-1][QW-2:0], ge};
        big_q[i] <= big_q[i-1];
        neg_q[i] <= neg_q[i-1];
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  // saturate the finished quotient
  assign res_o = qrs_pkg::sat_word(neg_q[NS-1],
                                   {33'b0, big_q[NS-1], quo_q[NS-1]});
  assign vld_o = vld_q[NS-1];
  assign tag_o = tag_q[NS-1];

endmodule

### tb/tb_top.sv
// Self-checking testbench for the quadratic root solver.
`timescale 1ns / 100ps

module tb_top;

  localparam int FRAC    = 16;
  localparam int LATENCY = 71;
  localparam int WD_MAX  = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  qrs_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  qrs_pkg::out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  // Tolerance as seen by the predictor
  logic [15:0] tol_q = '0;
  qrs_pkg::out_item_t root_queue[$];
  int err_cnt = 0;
  int sent_cnt = 0;
  int recv_cnt = 0;
  int idle_cycles = 0;
  int stall_mode = 0;

  quadratic_root_solver DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Saturate sign/magnitude to a 32-bit word
  function automatic logic [31:0] clamp_word(input bit neg, input logic [67:0] mag,
                                             inout bit ovf);
    if (!neg || mag == 0) begin
      if (mag > 68'h7FFF_FFFF) begin ovf = 1; return 32'h7FFF_FFFF; end
      return mag[31:0];
    end
    if (mag > 68'h8000_0000) begin ovf = 1; return 32'h8000_0000; end
    return -mag[31:0];
  endfunction

  function automatic logic [31:0] quot_word(input bit neg, input logic [67:0] num,
                                            input logic [67:0] den, inout bit ovf);
    logic [67:0] q;
    q = (num << FRAC) / den;
    return clamp_word(neg && q != 0, q, ovf);
  endfunction

  function automatic logic [33:0] sqrt_floor(input logic [67:0] v);
    logic [67:0] r, b;
    r = 0;
    b = 68'h1 << 66;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
      else r >>= 1;
      b >>= 2;
    end
    return r[33:0];
  endfunction

  // Classify the equation and compute roots, discriminant, overflow
  function automatic qrs_pkg::out_item_t solve_quadratic(input qrs_pkg::in_item_t it);
    qrs_pkg::out_item_t o;
    bit ovf, an, bn, cn, dneg, bneg, ng;
    logic [67:0] am, bm, cm, p, m4, dmag, s, den, nm;
    logic signed [69:0] nb, t;
    ovf = 0;
    o = '0;
    an = it.coef_quad[31]; bn = it.coef_lin[31]; cn = it.coef_const[31];
    am = an ? -{{36{1'b1}}, it.coef_quad} : {36'h0, it.coef_quad};
    bm = bn ? -{{36{1'b1}}, it.coef_lin} : {36'h0, it.coef_lin};
    cm = cn ? -{{36{1'b1}}, it.coef_const} : {36'h0, it.coef_const};
    if (am == 0 || am < tol_q) begin
      if (bm == 0 || bm < tol_q)
        o.case_code = (cm == 0 || cm < tol_q) ? qrs_pkg::CODE_INF : qrs_pkg::CODE_NONE;
      else begin
        o.case_code = qrs_pkg::CODE_LIN;
        o.root_one = quot_word(cn == bn, cm, bm, ovf);
        o.root_two = o.root_one;
      end
    end else begin
      p = bm * bm;
      m4 = (am * cm) << 2;
      if (an != cn && m4 != 0) begin dmag = p + m4; dneg = 0; end
      else if (p >= m4) begin dmag = p - m4; dneg = 0; end
      else begin dmag = m4 - p; dneg = 1; end
      o.discriminant = clamp_word(dneg && (dmag >> FRAC) != 0, dmag >> FRAC, ovf);
      nb = bn ? $signed({2'b0, bm}) : -$signed({2'b0, bm});
      bneg = nb < 0;
      den = am << 1;
      if (dmag < (68'(tol_q) << FRAC) || dmag == 0) begin
        o.case_code = qrs_pkg::CODE_DBL;
        o.root_one = quot_word(bneg != an, bm, den, ovf);
        o.root_two = o.root_one;
      end else begin
        s = 68'(sqrt_floor(dmag));
        if (!dneg) begin
          o.case_code = qrs_pkg::CODE_TWO;
          t = nb + $signed({2'b0, s});
          ng = t < 0; nm = 68'(ng ? -t : t);
          o.root_one = quot_word(ng != an, nm, den, ovf);
          t = nb - $signed({2'b0, s});
          ng = t < 0; nm = 68'(ng ? -t : t);
          o.root_two = quot_word(ng != an, nm, den, ovf);
        end else begin
          o.case_code = qrs_pkg::CODE_CPX;
          o.root_one = quot_word(bneg != an, bm, den, ovf);
          o.root_two = quot_word(an, s, den, ovf);
        end
      end
    end
    o.overflow = ovf;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s at result %0d: got %h expected %h", what, recv_cnt, got, want);
    err_cnt++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    qrs_pkg::out_item_t exp_item;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (root_queue.size() == 0) report_mismatch("unexpected result", 0, 0);
      else begin
        exp_item = root_queue.pop_front();
        if (out_data_o.case_code !== exp_item.case_code)
          report_mismatch("case_code", 32'(out_data_o.case_code),
                          32'(exp_item.case_code));
        if (out_data_o.root_one !== exp_item.root_one)
          report_mismatch("root_one", out_data_o.root_one, exp_item.root_one);
        if (out_data_o.root_two !== exp_item.root_two)
          report_mismatch("root_two", out_data_o.root_two, exp_item.root_two);
        if (out_data_o.discriminant !== exp_item.discriminant)
          report_mismatch("discriminant", out_data_o.discriminant, exp_item.discriminant);
        if (out_data_o.overflow !== exp_item.overflow)
          report_mismatch("overflow", 32'(out_data_o.overflow), 32'(exp_item.overflow));
      end
      recv_cnt++;
    end
  end

  // Receiver stall pattern: modes change every so often
  always @(posedge clk_i) begin
    int k;
    k = $urandom_range(0, 99);
    if (k == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= (k % 8) < 6;
    endcase
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_MAX) begin
      $display("Watchdog timeout");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one coefficient set; valid stays high across back-to-back items
  int burst_left = 0;
  task automatic send_coefs(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c);
    qrs_pkg::in_item_t it;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    it.coef_quad = a; it.coef_lin = b; it.coef_const = c;
    in_data_i <= it;
    in_valid_i <= 1'b1;
    root_queue.push_back(solve_quadratic(it));
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (root_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [15:0] v);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tol_q = v;
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 4) << 16;
      2: return -($urandom_range(0, 4) << 16);
      3: return $signed($urandom_range(0, 65535)) - 32768;
      4: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
      default: return $urandom_range(0, 2) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic test_directed();
    write_tolerance(16'd0);
    send_coefs(0, 0, 0);
    send_coefs(0, 0, 32'h0001_0000);
    send_coefs(0, 32'h0002_0000, 32'h0004_0000);
    send_coefs(0, 32'h0000_0001, 32'h7FFF_FFFF);
    send_coefs(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
    send_coefs(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);
    send_coefs(32'h0001_0000, 0, 32'h0001_0000);
    send_coefs(32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000);
    send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_coefs(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
    send_coefs(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coefs(32'h0000_0001, 0, 32'h7FFF_FFFF);
    send_coefs(32'h8000_0000, 0, 32'h8000_0000);
    send_coefs(32'h0000_0001, 32'h0000_0001, 0);
    send_coefs(32'h7FFF_FFFF, 0, 0);
    write_tolerance(16'hFFFF);
    send_coefs(32'h0000_FFFE, 32'h0000_FFFE, 32'h0000_FFFE);
    send_coefs(32'h0000_FFFE, 32'h0001_0000, 32'h0000_0005);
    send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0040);
    send_coefs(32'h0001_0000, 32'h8000_0000, 32'h0000_8000);
    send_coefs(32'hFFFF_0001, 32'h0000_1000, 32'h0003_0000);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_coefs(rand_coef(), rand_coef(), rand_coef());
  endtask

  // Sender holds off until every result has arrived
  task automatic test_full_drain();
    test_random(40);
    drain_results();
    test_random(40);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_tolerance(16'd0);
    test_random(250);
    write_tolerance(16'd3);
    test_full_drain();
    write_tolerance(16'h0100);
    test_random(250);
    write_tolerance(16'hFFFF);
    test_random(200);
    write_tolerance(16'($urandom_range(1, 65534)));
    test_random(100);
    drain_results();
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Covered %0d coefficient sets across a range of tolerance values, %0d results checked",
             sent_cnt, recv_cnt);
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### files.f
hdl/qrs_pkg.sv
hdl/qrs_sqrt.sv
hdl/qrs_div.sv
hdl/quadratic_root_solver.sv
tb/tb_top.sv
